// ----- rtl/gsa_pkg.sv -----
// Package for the generational slot allocator: field widths, operation and
// status codes, controller states and parameter defaults.
// No dependencies; compiled first.
package gsa_pkg;

	localparam int KIND_W   = 2;
	localparam int IDX_W    = 10;
	localparam int TAG_W    = 16;
	localparam int ETYPE_W  = 8;
	localparam int STATUS_W = 2;

	localparam int SLOT_COUNT_DEF = 1024;
	localparam int GEN_BITS_DEF   = 16;
	localparam int TYPE_BITS_DEF  = 8;

	typedef enum logic [KIND_W-1:0] {
		KIND_ALLOC  = 2'd0,
		KIND_FREE   = 2'd1,
		KIND_LOOKUP = 2'd2
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK      = 2'd0,
		STATUS_FULL    = 2'd1,
		STATUS_INVALID = 2'd2,
		STATUS_IGNORED = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} state_t;

endpackage

// ----- rtl/gsa_if.sv -----
// Channel interfaces of the generational slot allocator: the request channel
// and the response channel, each with valid, ready and payload.
// Depends on gsa_pkg.
interface gsa_req_if;
	import gsa_pkg::*;
	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   kind;
	logic [IDX_W-1:0]    slot_index;
	logic [TAG_W-1:0]    generation_tag;
	logic [ETYPE_W-1:0]  entity_type;

	modport source (output valid, kind, slot_index, generation_tag, entity_type,
		input ready);
	modport sink (input valid, kind, slot_index, generation_tag, entity_type,
		output ready);
endinterface

interface gsa_rsp_if;
	import gsa_pkg::*;
	logic                valid;
	logic                ready;
	status_t             status;
	logic [IDX_W-1:0]    result_slot;
	logic [TAG_W-1:0]    result_generation;
	logic [ETYPE_W-1:0]  result_type;

	modport source (output valid, status, result_slot, result_generation, result_type,
		input ready);
	modport sink (input valid, status, result_slot, result_generation, result_type,
		output ready);
endinterface

// ----- rtl/gsa_slot_ram.sv -----
// Slot table memory: one write port and one read port with registered read
// data. Holds one packed entry per slot. No package dependency.
module gsa_slot_ram #(
	parameter int DEPTH  = 1024,
	parameter int WIDTH  = 36,
	parameter int ADDR_W = 10
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// ----- rtl/generational_slot_allocator_top.sv -----
// Generational slot allocator, top level. Uses gsa_pkg, the channel
// interfaces in gsa_if.sv and the slot table memory gsa_slot_ram.
//
// Each request transfer on req carries one operation: allocate, free or
// lookup. Each one yields exactly one response transfer on rsp, in order.
// Allocate pops the free list or takes the next never-used slot and returns
// the slot with its generation. Free releases a live slot and bumps its
// generation. Lookup returns the stored type if slot and generation match.
// All per-slot state lives in one memory with a registered read; an operation
// reads its entry in the cycle of the request transfer and writes it back when
// the response is loaded into the output register. A new request is taken
// only once the previous one has finished its read-modify-write of the memory.
// After reset the block sweeps the memory to clear the used bits and the
// generations, one slot a cycle over all SLOT_COUNT slots, with req.ready low.
// If the receiver stalls, one finished response waits in the output register
// while the next request is still taken; that request's write-back then waits
// until the output register is free.
module generational_slot_allocator_top #(
	parameter int SLOT_COUNT = gsa_pkg::SLOT_COUNT_DEF,
	parameter int GEN_BITS   = gsa_pkg::GEN_BITS_DEF,
	parameter int TYPE_BITS  = gsa_pkg::TYPE_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	gsa_req_if.sink   req,
	gsa_rsp_if.source rsp
);
	import gsa_pkg::*;

	localparam int SLOT_W  = $clog2(SLOT_COUNT);
	localparam int FRESH_W = $clog2(SLOT_COUNT + 1);
	localparam logic [FRESH_W-1:0] FRESH_FULL = FRESH_W'(SLOT_COUNT);
	localparam logic [SLOT_W-1:0]  LAST_SLOT  = SLOT_W'(SLOT_COUNT - 1);

	typedef struct packed {
		logic                 used;
		logic [GEN_BITS-1:0]  gen;
		logic [TYPE_BITS-1:0] etype;
		logic [SLOT_W-1:0]    link;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	state_t state_q, state_d;
	logic [SLOT_W-1:0]    clr_q;
	logic [SLOT_W-1:0]    head_q, head_d;
	logic [FRESH_W-1:0]   fresh_q, fresh_d;

	logic [KIND_W-1:0]    kind_s1;
	logic [SLOT_W-1:0]    addr_s1;
	logic                 idx_ok_s1;
	logic                 from_list_s1;
	logic                 full_s1;
	logic [GEN_BITS-1:0]  tag_s1;
	logic [TYPE_BITS-1:0] etype_s1;

	logic                 rsp_valid_q;
	status_t              status_q;
	logic [IDX_W-1:0]     slot_q;
	logic [TAG_W-1:0]     gen_q;
	logic [ETYPE_W-1:0]   type_q;

	logic                 accept, finish, out_free;
	logic                 idx_ok, take_list, full;
	logic [SLOT_W-1:0]    idx_s, rd_addr;
	logic                 we;
	logic [SLOT_W-1:0]    waddr;
	entry_t               wdata, rd;
	logic [ENTRY_W-1:0]   rdata;
	status_t              res_status;
	logic [SLOT_W-1:0]    res_slot;
	logic [GEN_BITS-1:0]  res_gen;
	logic [TYPE_BITS-1:0] res_type;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign finish    = (state_q == ST_EXEC) && out_free;

	assign idx_ok    = (req.slot_index != '0) && (32'(req.slot_index) < 32'(SLOT_COUNT));
	assign idx_s     = SLOT_W'(32'(req.slot_index));
	assign take_list = (head_q != '0);
	assign full      = !take_list && (fresh_q == FRESH_FULL);
	assign rd_addr   = (req.kind == KIND_ALLOC) ?
		(take_list ? head_q : SLOT_W'(fresh_q)) : idx_s;

	gsa_slot_ram #(
		.DEPTH  (SLOT_COUNT),
		.WIDTH  (ENTRY_W),
		.ADDR_W (SLOT_W)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (accept),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	assign rd = entry_t'(rdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			head_q  <= '0;
			fresh_q <= FRESH_W'(1);
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			fresh_q <= fresh_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == LAST_SLOT) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (finish) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1      <= req.kind;
			addr_s1      <= rd_addr;
			idx_ok_s1    <= idx_ok;
			from_list_s1 <= take_list;
			full_s1      <= full;
			tag_s1       <= GEN_BITS'(32'(req.generation_tag));
			etype_s1     <= TYPE_BITS'(32'(req.entity_type));
		end
	end

	always_comb begin
		we         = 1'b0;
		waddr      = addr_s1;
		wdata      = '0;
		res_status = STATUS_INVALID;
		res_slot   = '0;
		res_gen    = '0;
		res_type   = '0;
		head_d     = head_q;
		fresh_d    = fresh_q;
		if (state_q == ST_CLEAR) begin
			we    = 1'b1;
			waddr = clr_q;
		end else if (finish) begin
			unique case (kind_s1)
				KIND_ALLOC: begin
					if (full_s1) begin
						res_status = STATUS_FULL;
					end else begin
						we          = 1'b1;
						wdata.used  = 1'b1;
						wdata.gen   = rd.gen;
						wdata.etype = etype_s1;
						res_status  = STATUS_OK;
						res_slot    = addr_s1;
						res_gen     = rd.gen;
						if (from_list_s1) begin
							head_d = rd.link;
						end else begin
							fresh_d = fresh_q + 1'b1;
						end
					end
				end
				KIND_FREE: begin
					if (idx_ok_s1 && rd.used) begin
						we         = 1'b1;
						wdata.gen  = rd.gen + 1'b1;
						wdata.link = head_q;
						head_d     = addr_s1;
						res_status = STATUS_OK;
					end else begin
						res_status = STATUS_IGNORED;
					end
				end
				KIND_LOOKUP: begin
					if (idx_ok_s1 && rd.used && (rd.gen == tag_s1)) begin
						res_status = STATUS_OK;
						res_slot   = addr_s1;
						res_gen    = rd.gen;
						res_type   = rd.etype;
					end
				end
				default: res_status = STATUS_INVALID;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (finish) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			status_q <= res_status;
			slot_q   <= IDX_W'(32'(res_slot));
			gen_q    <= TAG_W'(32'(res_gen));
			type_q   <= ETYPE_W'(32'(res_type));
		end
	end

	assign rsp.valid             = rsp_valid_q;
	assign rsp.status            = status_q;
	assign rsp.result_slot       = slot_q;
	assign rsp.result_generation = gen_q;
	assign rsp.result_type       = type_q;

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !req.ready)
		else $error("Request taken during the clearing sweep.");

	a_accept_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_EXEC))
		else $error("Request transfer not followed by execution.");

	a_alloc_not_nil: assert property (@(posedge clk) disable iff (!arst_n)
		(finish && (kind_s1 == KIND_ALLOC) && !full_s1) |-> (addr_s1 != '0))
		else $error("Allocation handed out the nil slot.");

	a_fresh_range: assert property (@(posedge clk) disable iff (!arst_n)
		(fresh_q != '0) && (fresh_q <= FRESH_FULL))
		else $error("Fresh slot counter out of range.");

endmodule
